/* sv/vlo_pkg.sv */
// ----------------------------------------------------------------------------
// vlo_pkg: shared types for the vertex layout offset decoder
// Holds the per-descriptor layout record that moves down the stage chain and
// the finished result record.
// ----------------------------------------------------------------------------
package vlo_pkg;

  localparam int MAX_TEX_STAGES = 8;
  localparam logic [5:0] OFF_ABSENT = 6'd63;

  // Attribute flag bit positions.
  localparam int FLAG_NORMAL   = 0;
  localparam int FLAG_DIFFUSE  = 1;
  localparam int FLAG_SPECULAR = 2;
  localparam int FLAG_FDIFFUSE = 3;
  localparam int FLAG_FSPEC    = 4;
  localparam int FLAG_TANGENT  = 5;
  localparam int FLAG_BINORMAL = 6;

  // Position kind codes.
  localparam logic [3:0] POS_NONE   = 4'd0;
  localparam logic [3:0] POS_XYZ    = 4'd1;
  localparam logic [3:0] POS_XYZRHW = 4'd2;
  localparam logic [3:0] POS_XYZW   = 4'd3;
  localparam logic [3:0] POS_B1     = 4'd4;
  localparam logic [3:0] POS_B5     = 4'd8;

  // Layout record: partial results plus the input fields still needed.
  typedef struct packed {
    logic [14:0] dims;
    logic [5:0]  w_off;
    logic [5:0]  p_off;
    logic [5:0]  n_off;
    logic [5:0]  c_off;
    logic [5:0]  s_off;
    logic [47:0] tex_offs;
    logic [5:0]  words;
    logic [4:0]  elems;
    logic [3:0]  tex_count;
    logic [23:0] tex_sizes;
    logic        has_tan;
    logic        has_bin;
  } lay_t;

  typedef struct packed {
    logic [14:0] dims;
    logic [5:0]  weight_offset;
    logic [5:0]  palette_offset;
    logic [5:0]  normal_offset;
    logic [5:0]  color_offset;
    logic [5:0]  specular_offset;
    logic [47:0] tex_offsets;
    logic [5:0]  tangent_offset;
    logic [5:0]  binormal_offset;
    logic [7:0]  total_bytes;
    logic [4:0]  element_count;
  } res_t;

endpackage

/* sv/vlo_head.sv */
// ----------------------------------------------------------------------------
// vlo_head: position and color decode
// First stage of the chain: places position, blend data, normal and colors,
// and saturates the texture stage count.
// ----------------------------------------------------------------------------
module vlo_head
  import vlo_pkg::*;
#(
  parameter int TEX_STAGES = MAX_TEX_STAGES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        up_valid,
  output logic        up_stall,
  input  logic [3:0]  pos_kind,
  input  logic        last_beta_byte,
  input  logic [6:0]  attr_flags,
  input  logic [3:0]  tex_count,
  input  logic [23:0] tex_sizes,
  output logic        dn_valid,
  input  logic        dn_stall,
  output lay_t        dn_lay
);

  localparam logic [3:0] STAGE_LIMIT = 4'(TEX_STAGES);

  logic valid_r;
  lay_t lay_r;
  lay_t lay_nxt;
  logic can_load;

  always_comb begin
    logic [2:0] pos_dim;
    logic [2:0] col_dim;
    logic [2:0] spec_dim;
    logic [2:0] wcount;
    logic [2:0] blends;
    blends   = 3'(pos_kind - POS_XYZW);
    pos_dim  = 3'd0;
    col_dim  = 3'd0;
    spec_dim = 3'd0;
    wcount   = 3'd0;
    lay_nxt  = '0;
    lay_nxt.w_off = OFF_ABSENT;
    lay_nxt.p_off = OFF_ABSENT;
    lay_nxt.n_off = OFF_ABSENT;
    lay_nxt.c_off = OFF_ABSENT;
    lay_nxt.s_off = OFF_ABSENT;
    lay_nxt.tex_offs = '1;

    if (pos_kind == POS_XYZ) begin
      pos_dim = 3'd3;
      lay_nxt.words = 6'd3;
      lay_nxt.elems = 5'd1;
    end else if (pos_kind == POS_XYZRHW || pos_kind == POS_XYZW) begin
      pos_dim = 3'd4;
      lay_nxt.words = 6'd4;
      lay_nxt.elems = 5'd1;
    end else if (pos_kind >= POS_B1 && pos_kind <= POS_B5) begin
      pos_dim = 3'd3;
      lay_nxt.words = 6'd3 + 6'(blends);
      if (last_beta_byte) begin
        // The last blend float carries the palette indices.
        lay_nxt.p_off = 6'd2 + 6'(blends);
        wcount = blends - 3'd1;
        if (wcount != 3'd0) begin
          lay_nxt.w_off = 6'd3;
          lay_nxt.elems = 5'd3;
        end else begin
          lay_nxt.elems = 5'd2;
        end
      end else begin
        lay_nxt.w_off = 6'd3;
        wcount = blends;
        lay_nxt.elems = 5'd2;
      end
    end

    if (attr_flags[FLAG_NORMAL]) begin
      lay_nxt.n_off = lay_nxt.words;
      lay_nxt.words = lay_nxt.words + 6'd3;
      lay_nxt.elems = lay_nxt.elems + 5'd1;
    end
    if (attr_flags[FLAG_DIFFUSE]) begin
      lay_nxt.c_off = lay_nxt.words;
      col_dim = 3'd1;
      lay_nxt.words = lay_nxt.words + 6'd1;
      lay_nxt.elems = lay_nxt.elems + 5'd1;
    end
    if (attr_flags[FLAG_SPECULAR]) begin
      lay_nxt.s_off = lay_nxt.words;
      spec_dim = 3'd1;
      lay_nxt.words = lay_nxt.words + 6'd1;
      lay_nxt.elems = lay_nxt.elems + 5'd1;
    end
    // Float colors come later in the vertex, so their offsets win.
    if (attr_flags[FLAG_FDIFFUSE]) begin
      lay_nxt.c_off = lay_nxt.words;
      col_dim = 3'd4;
      lay_nxt.words = lay_nxt.words + 6'd4;
      lay_nxt.elems = lay_nxt.elems + 5'd1;
    end
    if (attr_flags[FLAG_FSPEC]) begin
      lay_nxt.s_off = lay_nxt.words;
      spec_dim = 3'd4;
      lay_nxt.words = lay_nxt.words + 6'd4;
      lay_nxt.elems = lay_nxt.elems + 5'd1;
    end

    lay_nxt.dims = {wcount, 3'd0, spec_dim, col_dim, pos_dim};
    lay_nxt.tex_count = (tex_count > STAGE_LIMIT) ? STAGE_LIMIT : tex_count;
    lay_nxt.tex_sizes = tex_sizes;
    lay_nxt.has_tan = attr_flags[FLAG_TANGENT];
    lay_nxt.has_bin = attr_flags[FLAG_BINORMAL];
  end

  assign can_load = !valid_r || !dn_stall;
  assign up_stall = !can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && up_valid) begin
      lay_r <= lay_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_lay   = lay_r;

endmodule

/* sv/vlo_cell.sv */
// ----------------------------------------------------------------------------
// vlo_cell: one texture coordinate stage
// Places texture stage IDX at the running word offset and passes the record on.
// ----------------------------------------------------------------------------
module vlo_cell
  import vlo_pkg::*;
#(
  parameter int IDX = 0
) (
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_stall,
  input  lay_t up_lay,
  output logic dn_valid,
  input  logic dn_stall,
  output lay_t dn_lay
);

  logic valid_r;
  lay_t lay_r;
  lay_t lay_nxt;
  logic can_load;

  always_comb begin
    logic [2:0] sz;
    sz = up_lay.tex_sizes[3*IDX +: 3];
    if (sz > 3'd4) begin
      sz = 3'd4;
    end
    lay_nxt = up_lay;
    if (4'(IDX) < up_lay.tex_count) begin
      lay_nxt.tex_offs[6*IDX +: 6] = up_lay.words;
      lay_nxt.words = up_lay.words + 6'(sz);
      // An empty stage keeps its offset but is not an element.
      if (sz != 3'd0) begin
        lay_nxt.elems = up_lay.elems + 5'd1;
      end
    end
  end

  assign can_load = !valid_r || !dn_stall;
  assign up_stall = !can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && up_valid) begin
      lay_r <= lay_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_lay   = lay_r;

endmodule

/* sv/vlo_tail.sv */
// ----------------------------------------------------------------------------
// vlo_tail: tangent, binormal and result register
// Last stage of the chain: places tangent and binormal and holds the finished
// layout until it is taken.
// ----------------------------------------------------------------------------
module vlo_tail
  import vlo_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic up_valid,
  output logic up_stall,
  input  lay_t up_lay,
  output logic dn_valid,
  input  logic dn_stall,
  output res_t dn_res
);

  logic valid_r;
  res_t res_r;
  res_t res_nxt;
  logic can_load;

  always_comb begin
    logic [5:0] words;
    logic [4:0] elems;
    logic [2:0] tan_dim;
    words   = up_lay.words;
    elems   = up_lay.elems;
    tan_dim = 3'd0;
    res_nxt.tangent_offset  = OFF_ABSENT;
    res_nxt.binormal_offset = OFF_ABSENT;
    if (up_lay.has_tan) begin
      res_nxt.tangent_offset = words;
      tan_dim = up_lay.has_bin ? 3'd3 : 3'd4;
      words = words + 6'(tan_dim);
      elems = elems + 5'd1;
    end
    if (up_lay.has_bin) begin
      res_nxt.binormal_offset = words;
      words = words + 6'd3;
      elems = elems + 5'd1;
    end
    res_nxt.dims            = {up_lay.dims[14:12], tan_dim, up_lay.dims[8:0]};
    res_nxt.weight_offset   = up_lay.w_off;
    res_nxt.palette_offset  = up_lay.p_off;
    res_nxt.normal_offset   = up_lay.n_off;
    res_nxt.color_offset    = up_lay.c_off;
    res_nxt.specular_offset = up_lay.s_off;
    res_nxt.tex_offsets     = up_lay.tex_offs;
    res_nxt.total_bytes     = {words, 2'b00};
    res_nxt.element_count   = elems;
  end

  assign can_load = !valid_r || !dn_stall;
  assign up_stall = !can_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && up_valid) begin
      res_r <= res_nxt;
    end
  end

  assign dn_valid = valid_r;
  assign dn_res   = res_r;

endmodule

/* sv/vertex_layout_offsets_top.sv */
// ----------------------------------------------------------------------------
// vertex_layout_offsets_top: vertex format layout decoder
// Turns one vertex format descriptor into attribute offsets, dimensions,
// vertex size and element count.
// ----------------------------------------------------------------------------
// The decoder accepts one descriptor per cycle while in_stall is low and
// returns its layout through a chain of registered stages. A head stage
// places position, blend data, normal and colors, a row of TEX_STAGES
// cells places one texture stage each, and a tail stage places tangent and
// binormal into the result register. Every stage has its own valid bit and
// takes new data whenever it is empty or its content moves on, so a stall
// on the result side closes up gaps in the chain before it reaches in_stall;
// in_stall follows out_stall combinationally through the chain.
module vertex_layout_offsets_top
  import vlo_pkg::*;
#(
  parameter int TEX_STAGES = MAX_TEX_STAGES
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_pos_kind,
  input  logic        in_last_beta_byte,
  input  logic [6:0]  in_attr_flags,
  input  logic [3:0]  in_tex_count,
  input  logic [23:0] in_tex_sizes,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [14:0] out_dims,
  output logic [5:0]  out_weight_offset,
  output logic [5:0]  out_palette_offset,
  output logic [5:0]  out_normal_offset,
  output logic [5:0]  out_color_offset,
  output logic [5:0]  out_specular_offset,
  output logic [47:0] out_tex_offsets,
  output logic [5:0]  out_tangent_offset,
  output logic [5:0]  out_binormal_offset,
  output logic [7:0]  out_total_bytes,
  output logic [4:0]  out_element_count
);

  logic link_valid [TEX_STAGES+1];
  logic link_stall [TEX_STAGES+1];
  lay_t link_lay   [TEX_STAGES+1];
  res_t res;

  vlo_head #(
    .TEX_STAGES(TEX_STAGES)
  ) u_head (
    .clk            (clk),
    .rst_n          (rst_n),
    .up_valid       (in_valid),
    .up_stall       (in_stall),
    .pos_kind       (in_pos_kind),
    .last_beta_byte (in_last_beta_byte),
    .attr_flags     (in_attr_flags),
    .tex_count      (in_tex_count),
    .tex_sizes      (in_tex_sizes),
    .dn_valid       (link_valid[0]),
    .dn_stall       (link_stall[0]),
    .dn_lay         (link_lay[0])
  );

  for (genvar i = 0; i < TEX_STAGES; i++) begin : g_cell
    vlo_cell #(
      .IDX(i)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .up_valid (link_valid[i]),
      .up_stall (link_stall[i]),
      .up_lay   (link_lay[i]),
      .dn_valid (link_valid[i+1]),
      .dn_stall (link_stall[i+1]),
      .dn_lay   (link_lay[i+1])
    );
  end

  vlo_tail u_tail (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (link_valid[TEX_STAGES]),
    .up_stall (link_stall[TEX_STAGES]),
    .up_lay   (link_lay[TEX_STAGES]),
    .dn_valid (out_valid),
    .dn_stall (out_stall),
    .dn_res   (res)
  );

  assign out_dims            = res.dims;
  assign out_weight_offset   = res.weight_offset;
  assign out_palette_offset  = res.palette_offset;
  assign out_normal_offset   = res.normal_offset;
  assign out_color_offset    = res.color_offset;
  assign out_specular_offset = res.specular_offset;
  assign out_tex_offsets     = res.tex_offsets;
  assign out_tangent_offset  = res.tangent_offset;
  assign out_binormal_offset = res.binormal_offset;
  assign out_total_bytes     = res.total_bytes;
  assign out_element_count   = res.element_count;

`ifndef SYNTHESIS
  // A waiting result must still be there on the next cycle.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_total_bytes))
    else $error("result dropped or changed while stalled");

  // The vertex never holds more than eighteen elements.
  a_elem_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_element_count <= 5'd18)
    else $error("element count out of range");

  // Blend weights are reported exactly when their count is nonzero.
  a_weight_dim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_weight_offset != OFF_ABSENT) == (out_dims[14:12] != 3'd0)))
    else $error("weight offset and weight count disagree");

  // Tangent dimension is set exactly when a tangent is placed.
  a_tan_dim: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_tangent_offset != OFF_ABSENT) == (out_dims[11:9] != 3'd0)))
    else $error("tangent offset and dimension disagree");
`endif

endmodule

/* tb/tb_vertex_layout_offsets_top.sv */
// ----------------------------------------------------------------------------
// tb_vertex_layout_offsets_top: self-checking bench for the layout decoder
// Drives vertex format descriptors through the valid/stall input channel and
// compares every layout that leaves the result channel, field by field,
// against an in-bench prediction. It runs a directed sweep of position kinds,
// color overrides, tangent forms and texture stage corner cases, followed by
// random descriptors with random idling on both channels. It also runs one
// long result-side hold-off, and full drains after the sweep and mid-run.
// ----------------------------------------------------------------------------
module tb_vertex_layout_offsets_top;
  import vlo_pkg::*;

  localparam int CLK_HALF     = 10;
  localparam int RESET_CYCLES = 10;
  localparam int LATENCY      = MAX_TEX_STAGES + 2;
  localparam int RANDOM_ITEMS = 1350;
  localparam int HOLD_CYCLES  = 300;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int PRINT_CAP    = 60;

  class layout_checker;
    res_t pending_layouts[$];
    int unsigned errors;

    function res_t predict_layout(logic [3:0] pos_kind, logic last_beta,
                                  logic [6:0] flags, logic [3:0] tex_count,
                                  logic [23:0] tex_sizes);
      res_t r;
      int unsigned words, elems, blends, sz, stages;
      logic [2:0] pos_dim, col_dim, spec_dim, tan_dim, wcount;
      r = '0;
      r.weight_offset   = OFF_ABSENT;
      r.palette_offset  = OFF_ABSENT;
      r.normal_offset   = OFF_ABSENT;
      r.color_offset    = OFF_ABSENT;
      r.specular_offset = OFF_ABSENT;
      r.tangent_offset  = OFF_ABSENT;
      r.binormal_offset = OFF_ABSENT;
      r.tex_offsets     = '1;
      words = 0;
      elems = 0;
      pos_dim = 0;
      col_dim = 0;
      spec_dim = 0;
      tan_dim = 0;
      wcount = 0;

      if (pos_kind == POS_XYZ) begin
        pos_dim = 3;
        words = 3;
        elems = 1;
      end else if (pos_kind == POS_XYZRHW || pos_kind == POS_XYZW) begin
        pos_dim = 4;
        words = 4;
        elems = 1;
      end else if (pos_kind >= POS_B1 && pos_kind <= POS_B5) begin
        blends = int'(pos_kind) - int'(POS_B1) + 1;
        pos_dim = 3;
        words = 3 + blends;
        if (last_beta) begin
          // The last blend float carries the palette indices.
          r.palette_offset = 6'(2 + blends);
          wcount = 3'(blends - 1);
          if (wcount != 0) begin
            r.weight_offset = 6'd3;
            elems = 3;
          end else begin
            elems = 2;
          end
        end else begin
          r.weight_offset = 6'd3;
          wcount = 3'(blends);
          elems = 2;
        end
      end

      if (flags[FLAG_NORMAL]) begin
        r.normal_offset = 6'(words);
        words += 3;
        elems++;
      end
      if (flags[FLAG_DIFFUSE]) begin
        r.color_offset = 6'(words);
        col_dim = 1;
        words += 1;
        elems++;
      end
      if (flags[FLAG_SPECULAR]) begin
        r.specular_offset = 6'(words);
        spec_dim = 1;
        words += 1;
        elems++;
      end
      // Float colors come after the byte colors and win the reported slot.
      if (flags[FLAG_FDIFFUSE]) begin
        r.color_offset = 6'(words);
        col_dim = 4;
        words += 4;
        elems++;
      end
      if (flags[FLAG_FSPEC]) begin
        r.specular_offset = 6'(words);
        spec_dim = 4;
        words += 4;
        elems++;
      end

      stages = (tex_count > MAX_TEX_STAGES) ? MAX_TEX_STAGES : tex_count;
      for (int st = 0; st < MAX_TEX_STAGES; st++) begin
        if (st < stages) begin
          sz = tex_sizes[3*st +: 3];
          if (sz > 4) sz = 4;
          r.tex_offsets[6*st +: 6] = 6'(words);
          words += sz;
          if (sz != 0) elems++;
        end
      end

      if (flags[FLAG_TANGENT]) begin
        r.tangent_offset = 6'(words);
        tan_dim = flags[FLAG_BINORMAL] ? 3'd3 : 3'd4;
        words += tan_dim;
        elems++;
      end
      if (flags[FLAG_BINORMAL]) begin
        r.binormal_offset = 6'(words);
        words += 3;
        elems++;
      end

      r.dims = {wcount, tan_dim, spec_dim, col_dim, pos_dim};
      r.total_bytes = 8'(words * 4);
      r.element_count = 5'(elems);
      return r;
    endfunction

    function void note_descriptor(logic [3:0] pos_kind, logic last_beta,
                                  logic [6:0] flags, logic [3:0] tex_count,
                                  logic [23:0] tex_sizes);
      pending_layouts.push_back(
        predict_layout(pos_kind, last_beta, flags, tex_count, tex_sizes));
    endfunction

    task report(string msg);
      if (errors < PRINT_CAP) $display("MISMATCH: %s", msg);
      errors++;
    endtask

    task check_layout(res_t got);
      res_t want;
      if (pending_layouts.size() == 0) begin
        report($sformatf("layout with no pending descriptor: %h", got));
      end else begin
        want = pending_layouts.pop_front();
        if (got.dims !== want.dims)
          report($sformatf("dims got %h expected %h", got.dims, want.dims));
        if (got.weight_offset !== want.weight_offset)
          report($sformatf("weight_offset got %0d expected %0d",
                           got.weight_offset, want.weight_offset));
        if (got.palette_offset !== want.palette_offset)
          report($sformatf("palette_offset got %0d expected %0d",
                           got.palette_offset, want.palette_offset));
        if (got.normal_offset !== want.normal_offset)
          report($sformatf("normal_offset got %0d expected %0d",
                           got.normal_offset, want.normal_offset));
        if (got.color_offset !== want.color_offset)
          report($sformatf("color_offset got %0d expected %0d",
                           got.color_offset, want.color_offset));
        if (got.specular_offset !== want.specular_offset)
          report($sformatf("specular_offset got %0d expected %0d",
                           got.specular_offset, want.specular_offset));
        if (got.tex_offsets !== want.tex_offsets)
          report($sformatf("tex_offsets got %h expected %h",
                           got.tex_offsets, want.tex_offsets));
        if (got.tangent_offset !== want.tangent_offset)
          report($sformatf("tangent_offset got %0d expected %0d",
                           got.tangent_offset, want.tangent_offset));
        if (got.binormal_offset !== want.binormal_offset)
          report($sformatf("binormal_offset got %0d expected %0d",
                           got.binormal_offset, want.binormal_offset));
        if (got.total_bytes !== want.total_bytes)
          report($sformatf("total_bytes got %0d expected %0d",
                           got.total_bytes, want.total_bytes));
        if (got.element_count !== want.element_count)
          report($sformatf("element_count got %0d expected %0d",
                           got.element_count, want.element_count));
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [3:0]  in_pos_kind = '0;
  logic        in_last_beta_byte = 1'b0;
  logic [6:0]  in_attr_flags = '0;
  logic [3:0]  in_tex_count = '0;
  logic [23:0] in_tex_sizes = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [14:0] out_dims;
  logic [5:0]  out_weight_offset;
  logic [5:0]  out_palette_offset;
  logic [5:0]  out_normal_offset;
  logic [5:0]  out_color_offset;
  logic [5:0]  out_specular_offset;
  logic [47:0] out_tex_offsets;
  logic [5:0]  out_tangent_offset;
  logic [5:0]  out_binormal_offset;
  logic [7:0]  out_total_bytes;
  logic [4:0]  out_element_count;

  layout_checker layouts;
  int unsigned   cycle_count = 0;
  bit            steady_phase = 1'b0;
  bit            hold_request = 1'b0;

  vertex_layout_offsets_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_pos_kind         (in_pos_kind),
    .in_last_beta_byte   (in_last_beta_byte),
    .in_attr_flags       (in_attr_flags),
    .in_tex_count        (in_tex_count),
    .in_tex_sizes        (in_tex_sizes),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_dims            (out_dims),
    .out_weight_offset   (out_weight_offset),
    .out_palette_offset  (out_palette_offset),
    .out_normal_offset   (out_normal_offset),
    .out_color_offset    (out_color_offset),
    .out_specular_offset (out_specular_offset),
    .out_tex_offsets     (out_tex_offsets),
    .out_tangent_offset  (out_tangent_offset),
    .out_binormal_offset (out_binormal_offset),
    .out_total_bytes     (out_total_bytes),
    .out_element_count   (out_element_count)
  );

  always #CLK_HALF clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Mostly short idle runs with an occasional long one.
  function automatic int unsigned idle_length();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  function automatic int unsigned sender_gap();
    if (steady_phase || $urandom_range(0, 1) == 0) return 0;
    return idle_length();
  endfunction

  // Called in the time step of a rising edge; returns in the time step of the
  // edge at which the descriptor transfer takes place.
  task automatic send_descriptor(input logic [3:0] pos_kind, input logic last_beta,
                                 input logic [6:0] flags, input logic [3:0] tex_count,
                                 input logic [23:0] tex_sizes, input int unsigned gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_pos_kind       <= pos_kind;
    in_last_beta_byte <= last_beta;
    in_attr_flags     <= flags;
    in_tex_count      <= tex_count;
    in_tex_sizes      <= tex_sizes;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    layouts.note_descriptor(pos_kind, last_beta, flags, tex_count, tex_sizes);
  endtask

  task automatic send_random_descriptor();
    logic [3:0] pos_kind;
    logic [3:0] tex_count;
    pos_kind  = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 8))
                                             : 4'($urandom_range(9, 15));
    tex_count = ($urandom_range(0, 99) < 85) ? 4'($urandom_range(0, 8))
                                             : 4'($urandom_range(9, 15));
    send_descriptor(pos_kind, 1'($urandom), 7'($urandom), tex_count,
                    24'($urandom), sender_gap());
  endtask

  // The sender stops until every layout it is owed has been checked.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (layouts.pending_layouts.size() != 0);
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    logic        next_stall;
    res_t        seen;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        seen = {out_dims, out_weight_offset, out_palette_offset, out_normal_offset,
                out_color_offset, out_specular_offset, out_tex_offsets,
                out_tangent_offset, out_binormal_offset, out_total_bytes,
                out_element_count};
        layouts.check_layout(seen);
      end
      if (stall_left > 0) begin
        stall_left--;
        next_stall = 1'b1;
      end else if (hold_request) begin
        hold_request = 1'b0;
        stall_left = HOLD_CYCLES - 1;
        next_stall = 1'b1;
      end else if (!steady_phase && $urandom_range(0, 3) == 0) begin
        stall_left = idle_length() - 1;
        next_stall = 1'b1;
      end else begin
        next_stall = 1'b0;
      end
      out_stall <= next_stall;
    end
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned burst;
    bit          hold_done;
    bit          drain_done;
    layouts = new();
    sent = 0;
    hold_done = 1'b0;
    drain_done = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed sweep over position kinds, color overrides, tangent forms and
    // texture stage corner cases.
    send_descriptor(POS_NONE,   1'b0, 7'h00, 4'd0,  24'h000000, 0);
    send_descriptor(POS_XYZ,    1'b0, 7'h03, 4'd1,  24'h000002, 0);
    send_descriptor(POS_XYZRHW, 1'b0, 7'h04, 4'd2,  24'h000019, 1);
    send_descriptor(POS_XYZW,   1'b0, 7'h7f, 4'd8,  24'h924924, 0);
    send_descriptor(POS_B1,     1'b1, 7'h00, 4'd0,  24'h000000, 0);
    send_descriptor(POS_B1,     1'b0, 7'h01, 4'd0,  24'h000000, 2);
    send_descriptor(POS_B5,     1'b1, 7'h7f, 4'd8,  24'hffffff, 0);
    send_descriptor(POS_B5,     1'b0, 7'h7f, 4'd15, 24'hffffff, 0);
    send_descriptor(4'd6,       1'b1, 7'h21, 4'd3,  24'h0001a3, 0);
    send_descriptor(POS_XYZRHW, 1'b1, 7'h02, 4'd1,  24'h000004, 0);
    send_descriptor(4'd9,       1'b1, 7'h01, 4'd1,  24'h000003, 3);
    send_descriptor(4'd15,      1'b0, 7'h00, 4'd0,  24'h000000, 0);
    send_descriptor(POS_XYZ,    1'b0, 7'h0a, 4'd0,  24'h000000, 0);
    send_descriptor(POS_XYZ,    1'b0, 7'h14, 4'd0,  24'h000000, 0);
    send_descriptor(POS_XYZ,    1'b0, 7'h1e, 4'd0,  24'h000000, 0);
    send_descriptor(POS_XYZ,    1'b0, 7'h20, 4'd0,  24'h000000, 0);
    send_descriptor(POS_XYZ,    1'b0, 7'h60, 4'd0,  24'h000000, 1);
    send_descriptor(POS_XYZ,    1'b0, 7'h40, 4'd0,  24'h000000, 0);
    send_descriptor(POS_XYZW,   1'b0, 7'h00, 4'd9,  24'h6db6db, 0);
    send_descriptor(POS_XYZ,    1'b0, 7'h00, 4'd3,  24'h000182, 0);
    send_descriptor(POS_XYZ,    1'b0, 7'h00, 4'd8,  24'h000000, 0);
    send_descriptor(POS_XYZ,    1'b0, 7'h00, 4'd8,  24'hfb6d75, 0);
    send_descriptor(4'd7,       1'b0, 7'h55, 4'd4,  24'h000a4b, 0);
    wait_for_drain();

    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(20, 80);
      steady_phase = ($urandom_range(0, 3) == 0);
      if (!hold_done && sent >= 400) begin
        // Long result-side hold-off while descriptors keep coming, so the
        // pipeline fills and backs up to the input.
        hold_done = 1'b1;
        steady_phase = 1'b1;
        hold_request = 1'b1;
        burst = 60;
      end else if (!drain_done && sent >= 800) begin
        drain_done = 1'b1;
        wait_for_drain();
      end
      repeat (burst) begin
        send_random_descriptor();
        sent++;
      end
    end
    steady_phase = 1'b0;
    in_valid <= 1'b0;

    while (layouts.pending_layouts.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);
    if (layouts.pending_layouts.size() != 0)
      layouts.report($sformatf("%0d layouts never arrived",
                               layouts.pending_layouts.size()));
    if (layouts.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/vlo_pkg.sv
sv/vlo_head.sv
sv/vlo_cell.sv
sv/vlo_tail.sv
sv/vertex_layout_offsets_top.sv
tb/tb_vertex_layout_offsets_top.sv
